// ===== sv/bur_pkg.sv =====
// ----------------------------------------------------------------------------
// bur_pkg
// Shared types and constants of the bilinear upscale/rotate sampler.
// ----------------------------------------------------------------------------
package bur_pkg;

  localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ROTATE_MODE   = 2'd2;

  localparam logic       ACTION_LOAD   = 1'b0;
  localparam logic       ACTION_SAMPLE = 1'b1;

  // cos/sin of 10 degrees, Q30
  localparam longint COS10_Q30 = 64'sd1057429273;
  localparam longint SIN10_Q30 = 64'sd186453311;

  // job fields sized for the widest supported configuration
  localparam int JOB_CW = 12;
  localparam int JOB_FW = 25;

  typedef struct packed {
    logic        action;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
  } out_t;

  typedef struct packed {
    logic              is_load;
    logic [JOB_CW-1:0] xi;
    logic [JOB_CW-1:0] yi;
    logic [JOB_FW-1:0] xf;
    logic [JOB_FW-1:0] yf;
    logic [23:0]       pixel;
  } job_t;

endpackage

// ===== sv/bur_front.sv =====
// ----------------------------------------------------------------------------
// bur_front
// Accepts items, maps sample coordinates to source space (optional rotation),
// clamps them and emits a job for the back end; drops out-of-range loads.
// ----------------------------------------------------------------------------
module bur_front #(
  parameter int MAX_SOURCE_WIDTH  = 512,
  parameter int MAX_SOURCE_HEIGHT = 512,
  parameter int FRACTION_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bur_pkg::in_t  in_data,
  input  logic [9:0]    source_width,
  input  logic [9:0]    source_height,
  input  logic          rotate_mode,
  output logic          job_valid,
  input  logic          job_ready,
  output bur_pkg::job_t job
);

  localparam int F   = FRACTION_BITS;
  localparam int CW  = F + 14;
  localparam int KW  = F + 2;
  localparam int PW  = CW + KW;
  localparam int SZW = $clog2(((MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                               MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT) + 1);
  localparam longint COS_R = (bur_pkg::COS10_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);
  localparam longint SIN_R = (bur_pkg::SIN10_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);
  localparam logic signed [KW-1:0] COS_K = KW'(COS_R);
  localparam logic signed [KW-1:0] SIN_K = KW'(SIN_R);
  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1 <<< (F - 2));

  typedef enum logic [2:0] {
    F_IDLE, F_DELTA, F_MUL, F_SUM, F_SPLIT, F_PUSH
  } state_t;

  state_t                 state;
  logic signed [CW-1:0]   sx, sy, dx, dy, rx, ry;
  logic signed [PW-1:0]   pxc, pys, pyc, pxs;
  logic [SZW-1:0]         w, h;
  logic [SZW-1:0]         w_c, h_c;
  logic signed [CW-1:0]   xcen, ycen;
  logic [CW-1:0]          ux, uy;
  bur_pkg::job_t          split_job;
  bur_pkg::job_t          load_job;

  always_comb begin
    if (source_width < 10'd2) begin
      w_c = SZW'(2);
    end else if (32'(source_width) > MAX_SOURCE_WIDTH) begin
      w_c = SZW'(MAX_SOURCE_WIDTH);
    end else begin
      w_c = SZW'(source_width);
    end
    if (source_height < 10'd2) begin
      h_c = SZW'(2);
    end else if (32'(source_height) > MAX_SOURCE_HEIGHT) begin
      h_c = SZW'(MAX_SOURCE_HEIGHT);
    end else begin
      h_c = SZW'(source_height);
    end
  end

  assign xcen = CW'(w - SZW'(1)) <<< (F - 1);
  assign ycen = CW'(h - SZW'(1)) <<< (F - 1);

  assign ux = rx[CW-1] ? '0 : rx;
  assign uy = ry[CW-1] ? '0 : ry;

  always_comb begin
    load_job         = '0;
    load_job.is_load = 1'b1;
    load_job.xi      = bur_pkg::JOB_CW'(in_data.column);
    load_job.yi      = bur_pkg::JOB_CW'(in_data.row);
    load_job.pixel   = {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  always_comb begin
    split_job = '0;
    split_job.is_load = 1'b0;
    if (32'(ux[CW-1:F]) >= 32'(w) - 32'd1) begin
      split_job.xi = bur_pkg::JOB_CW'(w - SZW'(2));
      split_job.xf = bur_pkg::JOB_FW'(33'd1 << F);
    end else begin
      split_job.xi = bur_pkg::JOB_CW'(ux[CW-1:F]);
      split_job.xf = bur_pkg::JOB_FW'(ux[F-1:0]);
    end
    if (32'(uy[CW-1:F]) >= 32'(h) - 32'd1) begin
      split_job.yi = bur_pkg::JOB_CW'(h - SZW'(2));
      split_job.yf = bur_pkg::JOB_FW'(33'd1 << F);
    end else begin
      split_job.yi = bur_pkg::JOB_CW'(uy[CW-1:F]);
      split_job.yf = bur_pkg::JOB_FW'(uy[F-1:0]);
    end
  end

  assign in_ready  = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            w   <= w_c;
            h   <= h_c;
            sx  <= (CW'(in_data.column) << (F - 1)) - QUARTER;
            sy  <= (CW'(in_data.row) << (F - 1)) - QUARTER;
            rx  <= (CW'(in_data.column) << (F - 1)) - QUARTER;
            ry  <= (CW'(in_data.row) << (F - 1)) - QUARTER;
            job <= load_job;
            if (in_data.action == bur_pkg::ACTION_LOAD) begin
              if (32'(in_data.column) < MAX_SOURCE_WIDTH &&
                  32'(in_data.row) < MAX_SOURCE_HEIGHT) begin
                state <= F_PUSH;
              end
            end else if (rotate_mode) begin
              state <= F_DELTA;
            end else begin
              state <= F_SPLIT;
            end
          end
        end
        F_DELTA: begin
          dx    <= sx - xcen;
          dy    <= sy - ycen;
          state <= F_MUL;
        end
        F_MUL: begin
          pxc   <= PW'(dx) * PW'(COS_K);
          pys   <= PW'(dy) * PW'(SIN_K);
          pyc   <= PW'(dy) * PW'(COS_K);
          pxs   <= PW'(dx) * PW'(SIN_K);
          state <= F_SUM;
        end
        F_SUM: begin
          rx    <= xcen + CW'((pxc + pys) >>> F);
          ry    <= ycen + CW'((pyc - pxs) >>> F);
          state <= F_SPLIT;
        end
        F_SPLIT: begin
          job   <= split_job;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bur_queue.sv =====
// ----------------------------------------------------------------------------
// bur_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module bur_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  bur_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bur_pkg::job_t pop_data
);

  bur_pkg::job_t entry [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/bur_back.sv =====
// ----------------------------------------------------------------------------
// bur_back
// Frame store and sample engine: writes loads, reads the 2x2 neighborhood
// through one port and blends it into the output register.
// ----------------------------------------------------------------------------
module bur_back #(
  parameter int MAX_SOURCE_WIDTH  = 512,
  parameter int MAX_SOURCE_HEIGHT = 512,
  parameter int FRACTION_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  bur_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output bur_pkg::out_t out_data
);

  localparam int F     = FRACTION_BITS;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = F + 1;
  localparam int TW    = F + 9;
  localparam int VW    = TW + WW + 1;

  typedef enum logic [3:0] {
    B_IDLE, B_ADDR, B_WR, B_RD0, B_RD1, B_RD2, B_RD3, B_RD4, B_LERP1, B_LERP2
  } state_t;

  state_t           state;
  bur_pkg::job_t    cur;
  logic [AW-1:0]    base;
  logic [AW-1:0]    addr;
  logic             we;
  logic             out_load;
  logic [23:0]      rdata;
  logic [23:0]      mem [DEPTH];
  logic [23:0]      p0, p1, p2, p3;
  logic [WW-1:0]    xf, yf, xr, yr;
  logic [TW-1:0]    top [3];
  logic [TW-1:0]    bot [3];
  logic [VW-1:0]    v   [3];

  assign xf = WW'(cur.xf);
  assign yf = WW'(cur.yf);
  assign xr = WW'(33'd1 << F) - xf;
  assign yr = WW'(33'd1 << F) - yf;

  always_comb begin
    case (state)
      B_RD1:   addr = base + AW'(1);
      B_RD2:   addr = base + AW'(MAX_SOURCE_WIDTH);
      B_RD3:   addr = base + AW'(MAX_SOURCE_WIDTH + 1);
      default: addr = base;
    endcase
  end

  assign we       = (state == B_WR);
  assign out_load = (state == B_LERP2) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= cur.pixel;
    end
    rdata <= mem[addr];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c] = VW'(top[c]) * VW'(yr) + VW'(bot[c]) * VW'(yf);
    end
  end

  assign job_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= B_ADDR;
          end
        end
        B_ADDR: begin
          base  <= AW'(32'(cur.yi) * MAX_SOURCE_WIDTH + 32'(cur.xi));
          state <= cur.is_load ? B_WR : B_RD0;
        end
        B_WR:  state <= B_IDLE;
        B_RD0: state <= B_RD1;
        B_RD1: begin
          p0    <= rdata;
          state <= B_RD2;
        end
        B_RD2: begin
          p1    <= rdata;
          state <= B_RD3;
        end
        B_RD3: begin
          p2    <= rdata;
          state <= B_RD4;
        end
        B_RD4: begin
          p3    <= rdata;
          state <= B_LERP1;
        end
        B_LERP1: begin
          for (int c = 0; c < 3; c++) begin
            top[c] <= TW'(p0[16-8*c +: 8]) * TW'(xr) + TW'(p1[16-8*c +: 8]) * TW'(xf);
            bot[c] <= TW'(p2[16-8*c +: 8]) * TW'(xr) + TW'(p3[16-8*c +: 8]) * TW'(xf);
          end
          state <= B_LERP2;
        end
        B_LERP2: begin
          if (out_load) begin
            out_data.red_out   <= v[0][2*F +: 8];
            out_data.green_out <= v[1][2*F +: 8];
            out_data.blue_out  <= v[2][2*F +: 8];
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bilinear_upscale_rotate_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_upscale_rotate_sampler
// 2x bilinear upscaler with optional 10 degree rotation about the center.
//
// Input channel (in_valid/in_ready/in_data): a load request writes one RGB
// pixel into the frame store; a sample request names a destination pixel of
// the doubled image and yields one interpolated RGB result.
// Output channel (out_valid/out_ready/out_data): one result per sample.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no request is in flight.
// A sample passes the front end's split and push states (with rotation:
// delta, multiply, sum first), then the back end: address, four reads of the
// single-port frame store, two blend stages. The back-end sequencer finishes
// one sample before it takes the next job; a load writes one store word.
// A two-entry queue decouples front and back. When the receiver stalls the
// result stays in the output register, the back end waits, the queue fills
// and in_ready drops. Reset clears control state and sets the size
// registers to 512 and rotation off; frame store contents are undefined.
// ----------------------------------------------------------------------------
module bilinear_upscale_rotate_sampler #(
  parameter int MAX_SOURCE_WIDTH  = 512,
  parameter int MAX_SOURCE_HEIGHT = 512,
  parameter int FRACTION_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bur_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bur_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_data
);

  logic [9:0]    source_width, source_height;
  logic          rotate_mode;
  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  bur_pkg::job_t fq_job, qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 10'd512;
      source_height <= 10'd512;
      rotate_mode   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bur_pkg::CFG_SOURCE_WIDTH:  source_width  <= cfg_data;
        bur_pkg::CFG_SOURCE_HEIGHT: source_height <= cfg_data;
        bur_pkg::CFG_ROTATE_MODE:   rotate_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bur_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .source_width (source_width),
    .source_height(source_height),
    .rotate_mode  (rotate_mode),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job          (fq_job)
  );

  bur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_job),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_job)
  );

  bur_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(qb_valid),
    .job_ready(qb_ready),
    .job      (qb_job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== dv/bur_checker.sv =====
// ----------------------------------------------------------------------------
// bur_checker
// Watches the request, result and config channels of the sampler, keeps its
// own frame store and settings, predicts each sample's RGB and compares it
// with the results in order.
// ----------------------------------------------------------------------------
module bur_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bur_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bur_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_data,
  output int            errors,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 512;
  localparam int MAXH = 512;
  localparam int FB   = 16;

  logic [23:0]    pixels [int];
  logic [9:0]     width_reg, height_reg;
  logic           rotate_reg;
  bur_pkg::out_t  expected_rgb [$];

  function automatic longint floor_q(longint v);
    return v >>> FB;
  endfunction

  function automatic void split(longint c, int size, output int base, output longint frac);
    longint u;
    longint ip;
    u = (c < 0) ? 0 : c;
    ip = u >> FB;
    if (ip >= size - 1) begin
      base = size - 2;
      frac = longint'(1) << FB;
    end else begin
      base = int'(ip);
      frac = u & ((longint'(1) << FB) - 1);
    end
  endfunction

  function automatic logic [23:0] texel_at(int x, int y);
    int a;
    a = y * MAXW + x;
    return pixels.exists(a) ? pixels[a] : 24'd0;
  endfunction

  function automatic bur_pkg::out_t blend_sample(logic [9:0] col, logic [9:0] row);
    int w, h, xi, yi, sh;
    longint sx, sy, cs, sn, xc, yc, dx, dy, xf, yf, one, top, bot;
    logic [23:0] p [4];
    logic [7:0] ch [3];
    w = (width_reg < 2) ? 2 : (width_reg > MAXW) ? MAXW : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > MAXH) ? MAXH : height_reg;
    one = longint'(1) << FB;
    sx = (longint'(col) << (FB - 1)) - (longint'(1) << (FB - 2));
    sy = (longint'(row) << (FB - 1)) - (longint'(1) << (FB - 2));
    if (rotate_reg) begin
      cs = (bur_pkg::COS10_Q30 + (longint'(1) << (29 - FB))) >>> (30 - FB);
      sn = (bur_pkg::SIN10_Q30 + (longint'(1) << (29 - FB))) >>> (30 - FB);
      xc = longint'(w - 1) << (FB - 1);
      yc = longint'(h - 1) << (FB - 1);
      dx = sx - xc;
      dy = sy - yc;
      sx = xc + floor_q(dx * cs + dy * sn);
      sy = yc + floor_q(dy * cs - dx * sn);
    end
    split(sx, w, xi, xf);
    split(sy, h, yi, yf);
    p[0] = texel_at(xi, yi);
    p[1] = texel_at(xi + 1, yi);
    p[2] = texel_at(xi, yi + 1);
    p[3] = texel_at(xi + 1, yi + 1);
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      top = longint'((p[0] >> sh) & 8'hff) * (one - xf) + longint'((p[1] >> sh) & 8'hff) * xf;
      bot = longint'((p[2] >> sh) & 8'hff) * (one - xf) + longint'((p[3] >> sh) & 8'hff) * xf;
      ch[k] = 8'((top * (one - yf) + bot * yf) >> (2 * FB));
    end
    return '{red_out: ch[0], green_out: ch[1], blue_out: ch[2]};
  endfunction

  assign pending = expected_rgb.size();

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      width_reg  <= 10'd512;
      height_reg <= 10'd512;
      rotate_reg <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bur_pkg::CFG_SOURCE_WIDTH:  width_reg  <= cfg_data;
          bur_pkg::CFG_SOURCE_HEIGHT: height_reg <= cfg_data;
          bur_pkg::CFG_ROTATE_MODE:   rotate_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.action == bur_pkg::ACTION_LOAD) begin
          if (in_data.column < MAXW && in_data.row < MAXH)
            pixels[int'(in_data.row) * MAXW + int'(in_data.column)] =
              {in_data.red_in, in_data.green_in, in_data.blue_in};
        end else begin
          expected_rgb.push_back(blend_sample(in_data.column, in_data.row));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          bur_pkg::out_t e;
          e = expected_rgb.pop_front();
          if (e.red_out !== out_data.red_out || e.green_out !== out_data.green_out ||
              e.blue_out !== out_data.blue_out) begin
            $display("%0t: rgb mismatch, expected %h actual %h", $time, e, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bilinear upscale/rotate sampler: fills the frame store,
// then samples it under several size and rotation settings with random
// gaps on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bur_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bur_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  int errors, pending;
  bit stim_done = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bilinear_upscale_rotate_sampler dut (.*);
  bur_checker checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(logic act, logic [9:0] col, logic [9:0] row, logic [23:0] rgb);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, column: col, row: row,
                  red_in: rgb[23:16], green_in: rgb[15:8], blue_in: rgb[7:0]};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_mode(logic [9:0] w, logic [9:0] h, logic rot);
    drain();
    write_reg(bur_pkg::CFG_SOURCE_WIDTH, w);
    write_reg(bur_pkg::CFG_SOURCE_HEIGHT, h);
    write_reg(bur_pkg::CFG_ROTATE_MODE, {9'd0, rot});
    cfg_valid <= 1'b0;
  endtask

  task automatic sample_rand(int n);
    for (int i = 0; i < n; i++)
      send(bur_pkg::ACTION_SAMPLE, 10'($urandom), 10'($urandom), 24'($urandom));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 99) < 4) out_ready <= 1'b0;
    else if (!out_ready) out_ready <= ($urandom_range(0, 99) < 40);
    else out_ready <= ($urandom_range(0, 99) < 85);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // small frame 8x8 fully written, plus two out-of-range loads
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++)
        send(bur_pkg::ACTION_LOAD, 10'(x), 10'(y), (x + y == 0) ? 24'hffffff : 24'($urandom));
    send(bur_pkg::ACTION_LOAD, 10'd1023, 10'd1023, 24'h123456);
    send(bur_pkg::ACTION_LOAD, 10'd600, 10'd3, 24'hffffff);
    set_mode(10'd8, 10'd8, 1'b0);
    send(bur_pkg::ACTION_SAMPLE, 10'd0, 10'd0, 24'hffffff);
    send(bur_pkg::ACTION_SAMPLE, 10'd1023, 10'd1023, '0);
    send(bur_pkg::ACTION_SAMPLE, 10'd15, 10'd15, '0);
    send(bur_pkg::ACTION_SAMPLE, 10'd5, 10'd2, '0);
    set_mode(10'd8, 10'd8, 1'b1);
    send(bur_pkg::ACTION_SAMPLE, 10'd0, 10'd1023, '0);
    send(bur_pkg::ACTION_SAMPLE, 10'd7, 10'd7, '0);
    set_mode(10'd0, 10'd1, 1'b0);
    send(bur_pkg::ACTION_SAMPLE, 10'd3, 10'd1, '0);
    set_mode(10'd1023, 10'd0, 1'b1);
    send(bur_pkg::ACTION_SAMPLE, 10'd2, 10'd2, '0);
    // random sizes 2..8 stay within the written 8x8 area; loads mix with samples
    set_mode(10'd8, 10'd8, 1'b0);
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(10'($urandom_range(2, 8)), 10'($urandom_range(2, 8)), ph[0]);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 9) < 2)
          send(bur_pkg::ACTION_LOAD, 10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
               24'($urandom));
        else
          sample_rand(1);
      end
    end
    // wide frame: fill rows 0..1 across all 512 columns then sample
    for (int x = 0; x < 512; x++) begin
      send(bur_pkg::ACTION_LOAD, 10'(x), 10'd0, 24'($urandom));
      send(bur_pkg::ACTION_LOAD, 10'(x), 10'd1, 24'($urandom));
    end
    set_mode(10'd512, 10'd2, 1'b0);
    sample_rand(80);
    set_mode(10'd512, 10'd2, 1'b1);
    sample_rand(40);
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
